// File: src/utf8_stream_validator_top_macros.svh
// Assertion macros for the UTF-8 stream validator.
// Each one checks a property on the rising edge of clk and is off while rst_n is low.
`ifndef UTF8_STREAM_VALIDATOR_TOP_MACROS_SVH
`define UTF8_STREAM_VALIDATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define UTF8V_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define UTF8V_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define UTF8V_ASSERT_NOW(lbl, ante, cons, msg)

`define UTF8V_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: src/utf8v_pkg.sv
package utf8v_pkg;

  localparam int unsigned CpW = 21;

  // Byte classes.
  localparam logic [7:0] ASCII_MAX   = 8'h7F;
  localparam logic [7:0] LEAD2_MASK  = 8'hE0;
  localparam logic [7:0] LEAD2_TAG   = 8'hC0;
  localparam logic [7:0] LEAD3_MASK  = 8'hF0;
  localparam logic [7:0] LEAD3_TAG   = 8'hE0;
  localparam logic [7:0] LEAD4_MASK  = 8'hF8;
  localparam logic [7:0] LEAD4_TAG   = 8'hF0;
  localparam logic [7:0] CONT_MASK   = 8'hC0;
  localparam logic [7:0] CONT_TAG    = 8'h80;
  localparam logic [7:0] PAY2_MASK   = 8'h1F;
  localparam logic [7:0] PAY3_MASK   = 8'h0F;
  localparam logic [7:0] PAY4_MASK   = 8'h07;
  localparam logic [7:0] CONT_PAY    = 8'h3F;
  localparam logic [7:0] LEAD2_MIN   = 8'h02;

  // Code point limits.
  localparam logic [CpW-1:0] MIN_3BYTE = 21'h000800;
  localparam logic [CpW-1:0] MIN_4BYTE = 21'h010000;
  localparam logic [CpW-1:0] SURR_LO   = 21'h00D800;
  localparam logic [CpW-1:0] SURR_HI   = 21'h00DFFF;
  localparam logic [CpW-1:0] CP_MAX    = 21'h10FFFF;

  // Continuation counts.
  localparam logic [1:0] SEQ_NONE = 2'd0;
  localparam logic [1:0] SEQ_TWO   = 2'd1;
  localparam logic [1:0] SEQ_THREE = 2'd2;
  localparam logic [1:0] SEQ_FOUR  = 2'd3;

  // Word kind carried in tuser.
  localparam logic CMD_DATA = 1'b0;
  localparam logic CMD_END  = 1'b1;

  typedef struct packed {
    logic [CpW-1:0] code_accum;
    logic [1:0]     bytes_pending;
    logic [1:0]     sequence_length;
    logic           error_flag;
  } state_t;

  typedef struct packed {
    logic error_seen;
    logic text_end;
    logic text_valid;
  } result_t;

endpackage

// File: src/utf8v_decode.sv
module utf8v_decode (
  input  utf8v_pkg::state_t  state_cur,
  input  logic               cmd,
  input  logic [7:0]         data_byte,
  output utf8v_pkg::state_t  state_nxt,
  output utf8v_pkg::result_t result
);
  import utf8v_pkg::*;

  state_t         err_state;
  logic [CpW-1:0] acc_cont;
  logic [1:0]     pend_cont;
  logic           bad_cp;
  logic           text_ok;

  always_comb begin
    err_state            = '0;
    err_state.error_flag = 1'b1;

    acc_cont  = {state_cur.code_accum[CpW-7:0], data_byte[5:0] & CONT_PAY[5:0]};
    pend_cont = state_cur.bytes_pending - 2'd1;
    bad_cp    = ((state_cur.sequence_length == SEQ_THREE) && (acc_cont < MIN_3BYTE)) ||
                ((state_cur.sequence_length == SEQ_FOUR) && (acc_cont < MIN_4BYTE)) ||
                ((acc_cont >= SURR_LO) && (acc_cont <= SURR_HI)) ||
                (acc_cont > CP_MAX);
    text_ok   = !state_cur.error_flag && (state_cur.bytes_pending == 2'd0);

    state_nxt = state_cur;
    result    = '0;

    if (cmd == CMD_END) begin
      // verdict, then start the next text clean
      state_nxt         = '0;
      result.error_seen = !text_ok;
      result.text_end   = 1'b1;
      result.text_valid = text_ok;
    end else begin
      if (!state_cur.error_flag) begin
        if (state_cur.bytes_pending != 2'd0) begin
          if ((data_byte & CONT_MASK) != CONT_TAG) begin
            state_nxt = err_state;
          end else if (pend_cont != 2'd0) begin
            state_nxt.code_accum    = acc_cont;
            state_nxt.bytes_pending = pend_cont;
          end else if (bad_cp) begin
            state_nxt = err_state;
          end else begin
            state_nxt = '0;
          end
        end else begin
          if (data_byte == 8'h00) begin
            state_nxt = err_state;
          end else if (data_byte <= ASCII_MAX) begin
            state_nxt = state_cur;
          end else if ((data_byte & LEAD2_MASK) == LEAD2_TAG) begin
            // reject the overlong leads C0 and C1
            if ((data_byte & PAY2_MASK) < LEAD2_MIN) begin
              state_nxt = err_state;
            end else begin
              state_nxt.code_accum      = {{(CpW-8){1'b0}}, data_byte & PAY2_MASK};
              state_nxt.bytes_pending   = SEQ_TWO;
              state_nxt.sequence_length = SEQ_TWO;
            end
          end else if ((data_byte & LEAD3_MASK) == LEAD3_TAG) begin
            state_nxt.code_accum      = {{(CpW-8){1'b0}}, data_byte & PAY3_MASK};
            state_nxt.bytes_pending   = SEQ_THREE;
            state_nxt.sequence_length = SEQ_THREE;
          end else if ((data_byte & LEAD4_MASK) == LEAD4_TAG) begin
            state_nxt.code_accum      = {{(CpW-8){1'b0}}, data_byte & PAY4_MASK};
            state_nxt.bytes_pending   = SEQ_FOUR;
            state_nxt.sequence_length = SEQ_FOUR;
          end else begin
            state_nxt = err_state;
          end
        end
      end
      result.error_seen = state_nxt.error_flag;
    end
  end

endmodule

// File: src/utf8_stream_validator_top.sv
// Channel   Dir  Ports                        Payload
// in_       in   tvalid tready tdata tuser    tdata[7:0] data_byte; tuser cmd (1 = end)
// out_      out  tvalid tready tdata tlast    tdata[0] error_seen, [1] text_valid; tlast text_end
//
// One word in, one word out. Sustained rate is one word per cycle while out_tready is high,
// through an input register, then the decode against the running state into the output register.
// rst_n (synchronous, active low) empties both stages and clears the decode state.
// A stall on out_tready holds the output register; the input register still fills,
// and in_tready drops only when both stages are full.
module utf8_stream_validator_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tuser,   // [0] cmd: 0 text byte, 1 end of text
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] error_seen, [1] text_valid, [7:2] zero
  output logic       out_tlast   // text_end
);
  import utf8v_pkg::*;

  `include "utf8_stream_validator_top_macros.svh"

  // Input register stage.
  logic       s1_valid_r;
  logic       s1_cmd_r;
  logic [7:0] s1_byte_r;

  // Decode state and output register.
  state_t  state_r;
  state_t  state_nxt;
  result_t result_nxt;
  result_t out_res_r;
  logic    out_valid_r;

  logic s2_free;
  logic s1_adv;
  logic in_fire;

  // Output register can load when empty or when its word leaves now.
  assign s2_free   = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && s2_free;
  assign in_tready = !s1_valid_r || s2_free;
  assign in_fire   = in_tvalid && in_tready;

  utf8v_decode u_decode (
    .state_cur (state_r),
    .cmd       (s1_cmd_r),
    .data_byte (s1_byte_r),
    .state_nxt (state_nxt),
    .result    (result_nxt)
  );

  // Input stage: load on accept, drop once handed on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_cmd_r  <= in_tuser;
      s1_byte_r <= in_tdata;
    end
  end

  // Decode state advances exactly when a word moves into the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= result_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_res_r.text_end;
  assign out_tdata  = {6'd0, out_res_r.text_valid, out_res_r.error_seen};

  // End-of-text verdict: error flag is the inverse of the valid flag.
  `UTF8V_ASSERT_NOW(a_end_verdict, out_tvalid && out_tlast,
                    out_tdata[0] != out_tdata[1], "end verdict flags disagree")
  // Text bytes never claim a valid text.
  `UTF8V_ASSERT_NOW(a_byte_no_valid, out_tvalid && !out_tlast,
                    !out_tdata[1], "text_valid set on a text byte")
  // End of text leaves the decode state clear.
  `UTF8V_ASSERT_NEXT(a_end_clears, s1_adv && (s1_cmd_r == CMD_END),
                     state_r == '0, "state not cleared after end of text")
  // An error holds until end of text.
  `UTF8V_ASSERT_NEXT(a_err_sticky, s1_adv && (s1_cmd_r == CMD_DATA) && state_r.error_flag,
                     state_r.error_flag, "error flag dropped within a text")

endmodule

// File: tb/utf8_stream_validator_top_tb.sv
module utf8_stream_validator_top_tb;
  import utf8v_pkg::*;

  // Scoreboard: tracks the decode state of the current text and keeps the
  // verdict words still owed by the block, oldest first.
  class utf8_scoreboard;
    logic [CpW-1:0] cp_acc;
    logic [1:0]     cont_left;
    logic [1:0]     cont_total;
    logic           text_err;
    result_t        verdicts[$];
    int unsigned    n_fail;
    int unsigned    n_checked;
    int unsigned    n_texts;
    int unsigned    n_bad_texts;

    function new();
      clear_text();
      n_fail      = 0;
      n_checked   = 0;
      n_texts     = 0;
      n_bad_texts = 0;
    endfunction

    function void clear_text();
      cp_acc     = '0;
      cont_left  = '0;
      cont_total = SEQ_NONE;
      text_err   = 1'b0;
    endfunction

    // Drop the open sequence and make the error sticky.
    function void flag_error();
      clear_text();
      text_err = 1'b1;
    endfunction

    function void take_lead(logic [7:0] b);
      if (b == 8'h00) begin
        flag_error();
      end else if (b <= ASCII_MAX) begin
        // plain ASCII, nothing to track
      end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
        cp_acc = CpW'(b & PAY2_MASK);
        if (cp_acc < CpW'(LEAD2_MIN)) begin
          flag_error();
        end else begin
          cont_left  = 2'd1;
          cont_total = SEQ_TWO;
        end
      end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
        cp_acc     = CpW'(b & PAY3_MASK);
        cont_left  = 2'd2;
        cont_total = SEQ_THREE;
      end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
        cp_acc     = CpW'(b & PAY4_MASK);
        cont_left  = 2'd3;
        cont_total = SEQ_FOUR;
      end else begin
        flag_error();
      end
    endfunction

    function void take_continuation(logic [7:0] b);
      logic bad;
      logic [7:0] pay;
      if ((b & CONT_MASK) != CONT_TAG) begin
        flag_error();
        return;
      end
      pay       = b & CONT_PAY;
      cp_acc    = {cp_acc[CpW-7:0], pay[5:0]};
      cont_left = cont_left - 2'd1;
      if (cont_left != 2'd0) return;
      // Sequence closed: reject overlong forms, surrogates and out-of-range.
      bad = (cont_total == SEQ_THREE && cp_acc < MIN_3BYTE) ||
            (cont_total == SEQ_FOUR  && cp_acc < MIN_4BYTE) ||
            (cp_acc >= SURR_LO && cp_acc <= SURR_HI) ||
            (cp_acc > CP_MAX);
      if (bad) begin
        flag_error();
      end else begin
        cp_acc     = '0;
        cont_total = SEQ_NONE;
      end
    endfunction

    // Note one accepted input word and queue the verdict it must produce.
    function void note_word(logic cmd, logic [7:0] b);
      result_t r;
      logic    ok;
      if (cmd == CMD_END) begin
        ok           = !text_err && cont_left == 2'd0;
        r.error_seen = !ok;
        r.text_end   = 1'b1;
        r.text_valid = ok;
        n_texts++;
        if (!ok) n_bad_texts++;
        clear_text();
      end else begin
        if (!text_err) begin
          if (cont_left != 2'd0) take_continuation(b);
          else take_lead(b);
        end
        r.error_seen = text_err;
        r.text_end   = 1'b0;
        r.text_valid = 1'b0;
      end
      verdicts.push_back(r);
    endfunction

    // Compare one accepted output word with the oldest queued verdict.
    function void check_word(logic [7:0] tdata, logic tlast);
      result_t exp_r;
      if (verdicts.size() == 0) begin
        $display("%0t: unexpected output word tdata=%h tlast=%b", $time, tdata, tlast);
        n_fail++;
        return;
      end
      exp_r = verdicts.pop_front();
      n_checked++;
      if (tdata[0] !== exp_r.error_seen) begin
        $display("%0t: error_seen expected %b got %b", $time, exp_r.error_seen, tdata[0]);
        n_fail++;
      end
      if (tlast !== exp_r.text_end) begin
        $display("%0t: text_end expected %b got %b", $time, exp_r.text_end, tlast);
        n_fail++;
      end
      if (tdata[1] !== exp_r.text_valid) begin
        $display("%0t: text_valid expected %b got %b", $time, exp_r.text_valid, tdata[1]);
        n_fail++;
      end
    endfunction

    function int unsigned outstanding();
      return verdicts.size();
    endfunction
  endclass

  localparam int unsigned NUM_WORDS      = 1250;
  localparam int unsigned IDLE_LIMIT     = 2000;  // far above the longest legal quiet stretch
  localparam int unsigned RX_HOLD_CYCLES = 80;    // long enough to fill both stages
  localparam int unsigned SETTLE_CYCLES  = 4;     // two-stage pipe plus margin

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] data_byte
  logic       in_tuser;   // [0] cmd
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [0] error_seen, [1] text_valid, [7:2] zero
  logic       out_tlast;  // text_end

  utf8_scoreboard sb;
  int unsigned    words_sent;
  int unsigned    burst_left;
  int unsigned    idle_cycles;
  bit             rx_hold_req;

  utf8_stream_validator_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Offer one word and hold it until the block takes it. The sender works in
  // bursts; between bursts it sometimes drops tvalid for a random gap. Called at a
  // rising edge, returns at the edge where the word was accepted.
  task automatic send_word(input logic cmd, input logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    sb.note_word(cmd, b);
    words_sent++;
    burst_left--;
  endtask

  // Stop offering and wait until every queued verdict has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // Encode a code point in the shortest form its value calls for; values that
  // need four bytes keep all 21 bits, so out-of-range points go out as well.
  task automatic send_code_point(input logic [CpW-1:0] cp);
    if (cp < 21'h80) begin
      send_word(CMD_DATA, cp[7:0]);
    end else if (cp < 21'h800) begin
      send_word(CMD_DATA, {3'b110, cp[10:6]});
      send_word(CMD_DATA, {2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      send_word(CMD_DATA, {4'b1110, cp[15:12]});
      send_word(CMD_DATA, {2'b10, cp[11:6]});
      send_word(CMD_DATA, {2'b10, cp[5:0]});
    end else begin
      send_word(CMD_DATA, {5'b11110, cp[20:18]});
      send_word(CMD_DATA, {2'b10, cp[17:12]});
      send_word(CMD_DATA, {2'b10, cp[11:6]});
      send_word(CMD_DATA, {2'b10, cp[5:0]});
    end
  endtask

  // Lead byte with random payload bits plus all of its continuations, or only some when
  // truncating; this hits overlong forms, surrogates, out-of-range points and truncation.
  task automatic send_raw_sequence(input bit truncate);
    int unsigned n_cont;
    int unsigned n_send;
    logic [7:0]  lead;
    n_cont = $urandom_range(1, 3);
    case (n_cont)
      1: lead = {3'b110, 5'($urandom_range(0, 31))};
      2: lead = ($urandom_range(0, 2) == 0) ? 8'hED : {4'b1110, 4'($urandom_range(0, 15))};
      default: lead = ($urandom_range(0, 1) == 0) ? {5'b11110, 3'($urandom_range(0, 4))} :
                                                    {5'b11110, 3'($urandom_range(0, 7))};
    endcase
    n_send = truncate ? $urandom_range(0, n_cont - 1) : n_cont;
    send_word(CMD_DATA, lead);
    repeat (n_send) send_word(CMD_DATA, {2'b10, 6'($urandom_range(0, 63))});
  endtask

  task automatic send_random_text();
    int unsigned n_chars;
    int unsigned pick;
    logic [CpW-1:0] edges[$] = '{21'h7F, 21'h80, 21'h7FF, 21'h800, 21'hD7FF, 21'hD800,
                                 21'hDFFF, 21'hE000, 21'hFFFF, 21'h10000, 21'h10FFFF,
                                 21'h110000, 21'h1FFFFF};
    n_chars = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
    repeat (n_chars) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        case ($urandom_range(0, 3))
          0: send_code_point(21'($urandom_range(1, 'h7F)));
          1: send_code_point(21'($urandom_range('h80, 'h7FF)));
          2: send_code_point(21'($urandom_range('h800, 'hFFFF)));
          default: send_code_point(21'($urandom_range('h10000, 'h10FFFF)));
        endcase
      end else if (pick < 62) begin
        send_code_point(edges[$urandom_range(0, edges.size() - 1)]);
      end else if (pick < 78) begin
        send_raw_sequence(1'b0);
      end else if (pick < 86) begin
        send_raw_sequence(1'b1);
      end else begin
        send_word(CMD_DATA, 8'($urandom_range(0, 255)));
      end
    end
    // data_byte is don't-care on an end marker; vary it anyway
    send_word(CMD_END, 8'($urandom_range(0, 255)));
  endtask

  // Receiver: stretches of always-ready, random stalls and a fixed stall
  // pattern, plus one long hold-off on request.
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned phase;
    logic        rdy;
    out_tready = 1'b0;
    phase      = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 64);
      repeat (span) begin
        if (rx_hold_req) begin
          out_tready <= 1'b0;
          repeat (RX_HOLD_CYCLES) @(posedge clk);
          rx_hold_req = 1'b0;
        end
        case (mode)
          0: rdy = 1'b1;
          1: rdy = ($urandom_range(0, 3) != 0);
          2: rdy = 1'($urandom_range(0, 1));
          default: rdy = (phase % 5 == 0) || (phase % 5 == 3);
        endcase
        phase++;
        out_tready <= rdy;
        @(posedge clk);
      end
    end
  end

  // Check every output word and watch for a hung handshake.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_word(out_tdata, out_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    // Directed texts, each closed by an end marker:
    //   empty text; ASCII max and smallest legal two-byte form;
    //   stray continuation, then a NUL that is ignored after the error;
    //   lead byte C1; overlong three-byte form; surrogate;
    //   point above the Unicode range; missing continuation;
    //   sequence left open at end of text.
    static logic [8:0] directed_words[$] = '{
      {CMD_END,  8'hFF},
      {CMD_DATA, 8'h7F}, {CMD_DATA, 8'hC2}, {CMD_DATA, 8'h80}, {CMD_END, 8'h00},
      {CMD_DATA, 8'h80}, {CMD_DATA, 8'h00}, {CMD_END, 8'h5A},
      {CMD_DATA, 8'hC1}, {CMD_END, 8'h00},
      {CMD_DATA, 8'hE0}, {CMD_DATA, 8'h80}, {CMD_DATA, 8'h80}, {CMD_END, 8'h00},
      {CMD_DATA, 8'hED}, {CMD_DATA, 8'hA0}, {CMD_DATA, 8'h80}, {CMD_END, 8'h00},
      {CMD_DATA, 8'hF4}, {CMD_DATA, 8'h90}, {CMD_DATA, 8'h80}, {CMD_DATA, 8'h80},
      {CMD_END,  8'h00},
      {CMD_DATA, 8'hE2}, {CMD_DATA, 8'h41}, {CMD_END, 8'h00},
      {CMD_DATA, 8'hF0}, {CMD_END, 8'h00}
    };
    bit hold_done;
    bit pause_done;

    sb          = new();
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    in_tuser    = CMD_DATA;
    words_sent  = 0;
    burst_left  = 0;
    idle_cycles = 0;
    rx_hold_req = 1'b0;
    hold_done   = 1'b0;
    pause_done  = 1'b0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_words[i]) send_word(directed_words[i][8], directed_words[i][7:0]);
    wait_drained();

    while (words_sent < NUM_WORDS) begin
      // Long receiver hold-off while the sender keeps pushing: fills the pipe.
      if (!hold_done && words_sent >= 400) begin
        rx_hold_req = 1'b1;
        burst_left  = 300;
        hold_done   = 1'b1;
      end
      // Let the pipe run dry once mid-stream.
      if (!pause_done && words_sent >= 800) begin
        wait_drained();
        pause_done = 1'b1;
      end
      send_random_text();
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.outstanding() != 0) begin
      $display("%0t: %0d verdicts never arrived", $time, sb.outstanding());
      sb.n_fail++;
    end

    $display("Run covered %0d input words in %0d texts (%0d invalid), %0d outputs checked",
             words_sent, sb.n_texts, sb.n_bad_texts, sb.n_checked);
    $display("Mismatches: %0d", sb.n_fail);
    if (sb.n_fail == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
